### rtl/core/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared widths, codes and types of the multi-queue ring fifo.
// ----------------------------------------------------------------------------
package mqf_pkg;

  // defaults of the top-level parameters
  localparam int unsigned NUM_QUEUES_DEF  = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // fixed field widths
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned STAT_W    = 16;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned QID_W     = 2;
  localparam int unsigned STATUS_W  = 2;

  // capacity registers
  localparam int unsigned NUM_CAP   = 4;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;
  localparam int unsigned CFG_IDX_W = $clog2(NUM_CAP);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_PEEK   = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_STATUS = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic [NUM_CAP-1:0][CAP_W-1:0] cap_arr_t;

endpackage

### rtl/core/mqf_if.sv
// ----------------------------------------------------------------------------
// mqf_if
// Channel interfaces: operation request, result and capacity write.
// ----------------------------------------------------------------------------
interface mqf_in_if;
  import mqf_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [QID_W-1:0]  queue_id;
  logic [ELEM_W-1:0] data_in;

  modport source (output valid, op, queue_id, data_in, input ready);
  modport sink   (input valid, op, queue_id, data_in, output ready);
endinterface

interface mqf_out_if;
  import mqf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ELEM_W-1:0]    data_out;
  logic [CNT_OUT_W-1:0] elem_count;
  logic [STAT_W-1:0]    insert_total;
  logic [STAT_W-1:0]    remove_total;
  logic [STAT_W-1:0]    empty_hits;
  logic [STAT_W-1:0]    full_hits;

  modport source (output valid, status, data_out, elem_count, insert_total,
                  remove_total, empty_hits, full_hits, input ready);
  modport sink   (input valid, status, data_out, elem_count, insert_total,
                  remove_total, empty_hits, full_hits, output ready);
endinterface

interface mqf_cfg_if;
  import mqf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAP_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/mqf_elem_ram.sv
// ----------------------------------------------------------------------------
// mqf_elem_ram
// Element store shared by all queues, one port, registered read data.
// ----------------------------------------------------------------------------
module mqf_elem_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mqf_state_ram.sv
// ----------------------------------------------------------------------------
// mqf_state_ram
// Per-queue state word (pointers, count, statistics) with valid bits;
// an entry never written since reset reads as all zeros.
// ----------------------------------------------------------------------------
module mqf_state_ram #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 77,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // valid bits stand in for the zero reset of every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mqf_ctrl.sv
// ----------------------------------------------------------------------------
// mqf_ctrl
// Operation sequencer: reads the queue state word, updates it and accesses
// the element store, then hands the result to the output register.
// ----------------------------------------------------------------------------
module mqf_ctrl #(
  parameter int unsigned NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned QS_W  = 2 * PTR_W + CNT_W + 4 * mqf_pkg::STAT_W,
  localparam int unsigned QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int unsigned EL_D  = NUM_QUEUES * QUEUE_DEPTH,
  localparam int unsigned AW    = (EL_D > 1) ? $clog2(EL_D) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mqf_in_if.sink                           req,
  mqf_out_if.source                        rsp,
  input  mqf_pkg::cap_arr_t                cap_i,
  // queue state memory
  output logic                             st_re_o,
  output logic [QIW-1:0]                   st_raddr_o,
  input  logic [QS_W-1:0]                  st_rdata_i,
  output logic                             st_we_o,
  output logic [QIW-1:0]                   st_waddr_o,
  output logic [QS_W-1:0]                  st_wdata_o,
  // element memory
  output logic                             el_we_o,
  output logic                             el_re_o,
  output logic [AW-1:0]                    el_addr_o,
  output logic [mqf_pkg::ELEM_W-1:0]       el_wdata_o,
  input  logic [mqf_pkg::ELEM_W-1:0]       el_rdata_i
);

  import mqf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_META = 3'b010,
    S_DATA = 3'b100
  } fsm_e;

  typedef struct packed {
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] ins;
    logic [STAT_W-1:0] rem;
    logic [STAT_W-1:0] emp;
    logic [STAT_W-1:0] ful;
  } qstate_t;

  fsm_e state_q, state_d;

  logic              in_acc;
  logic              load;
  logic              is_meta;

  // captured request
  logic [OP_W-1:0]   op_q;
  logic [QID_W-1:0]  qid_q;
  logic [ELEM_W-1:0] din_q;
  logic              qok_q;
  logic [QIW-1:0]    qidx_q;

  // read-modify-write of the state word
  qstate_t           cur, nxt;
  status_e           status;
  logic              el_we, el_re;
  logic              full, empty;
  logic [CNT_W-1:0]  cap_eff;
  logic [CAP_W-1:0]  cap_raw;
  logic [AW-1:0]     base;
  logic [PTR_W-1:0]  el_ptr;

  // result held between state update and output load
  status_e              res_status_q;
  logic                 res_hit_q;
  logic [CNT_OUT_W-1:0] res_cnt_q;
  logic [STAT_W-1:0]    res_ins_q, res_rem_q, res_emp_q, res_ful_q;

  // output register
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ELEM_W-1:0]    out_data_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [STAT_W-1:0]    out_ins_q, out_rem_q, out_emp_q, out_ful_q;

  // handshake
  assign is_meta   = (state_q == S_META);
  assign load      = (state_q == S_DATA) && (!out_valid_q || rsp.ready);
  assign req.ready = (state_q == S_IDLE) || load;
  assign in_acc    = req.valid && req.ready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_META;
        end
      end
      S_META: begin
        state_d = S_DATA;
      end
      S_DATA: begin
        if (load) begin
          state_d = in_acc ? S_META : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= req.op;
      qid_q <= req.queue_id;
      din_q <= req.data_in;
      qok_q <= (32'(req.queue_id) < NUM_QUEUES);
    end
  end

  assign qidx_q = QIW'(qid_q);

  // state word read issued with the accepted beat
  assign st_re_o    = in_acc;
  assign st_raddr_o = QIW'(req.queue_id);

  // capacity, saturated at the physical depth
  assign cap_raw = cap_i[qid_q];
  assign cap_eff = (32'(cap_raw) > QUEUE_DEPTH) ? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_raw);

  assign cur   = qstate_t'(st_rdata_i);
  assign full  = (cur.count >= cap_eff);
  assign empty = (cur.count == '0);

  // operation decode and state update
  always_comb begin
    nxt    = cur;
    status = ST_OK;
    el_we  = 1'b0;
    el_re  = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          nxt.ful = cur.ful + 1'b1;
          status  = ST_FULL;
        end else begin
          el_we      = 1'b1;
          nxt.wr_ptr = (cur.wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur.wr_ptr + 1'b1;
          nxt.count  = cur.count + 1'b1;
          nxt.ins    = cur.ins + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          nxt.emp = cur.emp + 1'b1;
          status  = ST_EMPTY;
        end else begin
          el_re      = 1'b1;
          nxt.rd_ptr = (cur.rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur.rd_ptr + 1'b1;
          nxt.count  = cur.count - 1'b1;
          nxt.rem    = cur.rem + 1'b1;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          el_re = 1'b1;
        end
      end
      OP_FLUSH: begin
        nxt.count  = '0;
        nxt.wr_ptr = '0;
        nxt.rd_ptr = '0;
      end
      OP_CLEAR: begin
        nxt.ins = '0;
        nxt.rem = '0;
        nxt.emp = '0;
        nxt.ful = '0;
      end
      default: begin
      end
    endcase
  end

  // state write-back, done before the next read can be issued
  assign st_we_o    = is_meta && qok_q;
  assign st_waddr_o = qidx_q;
  assign st_wdata_o = nxt;

  // element access within the queue's slot range
  assign base       = AW'(qidx_q) * AW'(QUEUE_DEPTH);
  assign el_ptr     = el_we ? cur.wr_ptr : cur.rd_ptr;
  assign el_addr_o  = base + AW'(el_ptr);
  assign el_we_o    = is_meta && qok_q && el_we;
  assign el_re_o    = is_meta && qok_q && el_re;
  assign el_wdata_o = din_q;

  // result fields; a queue id out of range answers all zeros
  always_ff @(posedge clk_i) begin
    if (is_meta) begin
      res_status_q <= qok_q ? status : ST_OK;
      res_hit_q    <= qok_q && el_re;
      res_cnt_q    <= qok_q ? CNT_OUT_W'(nxt.count) : '0;
      res_ins_q    <= qok_q ? nxt.ins : '0;
      res_rem_q    <= qok_q ? nxt.rem : '0;
      res_emp_q    <= qok_q ? nxt.emp : '0;
      res_ful_q    <= qok_q ? nxt.ful : '0;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_hit_q ? el_rdata_i : '0;
      out_cnt_q    <= res_cnt_q;
      out_ins_q    <= res_ins_q;
      out_rem_q    <= res_rem_q;
      out_emp_q    <= res_emp_q;
      out_ful_q    <= res_ful_q;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.data_out     = out_data_q;
  assign rsp.elem_count   = out_cnt_q;
  assign rsp.insert_total = out_ins_q;
  assign rsp.remove_total = out_rem_q;
  assign rsp.empty_hits   = out_emp_q;
  assign rsp.full_hits    = out_ful_q;

endmodule

### rtl/core/multi_queue_ring_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo
// Several circular FIFOs over one element store, with per-queue counts,
// capacities and wrapping statistics.
//
//   channel | dir | beat
//   --------+-----+-----------------------------------------------------------
//   req_i   | in  | op, queue_id, data_in
//   rsp_o   | out | status, data_out, elem_count, four statistics counters
//   cfg_i   | in  | index, data: capacity of queue 0..3
//
// A request is accepted while idle or as the last result loads: the queue
// state word is read from its memory, then written back while the element
// store is accessed; the result is registered, then loaded into the output
// register. Reset sets all capacities to 16 and marks every state word as
// zero; no clearing pass. A waiting result does not block the next request;
// the sequencer holds only when a new result meets an occupied output register.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo #(
  parameter int unsigned NUM_QUEUES  = mqf_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = mqf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mqf_in_if.sink    req_i,
  mqf_out_if.source rsp_o,
  mqf_cfg_if.sink   cfg_i
);

  import mqf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QS_W  = 2 * PTR_W + CNT_W + 4 * STAT_W;
  localparam int unsigned QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned EL_D  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW    = (EL_D > 1) ? $clog2(EL_D) : 1;

  cap_arr_t          cap_q;

  logic              st_re, st_we;
  logic [QIW-1:0]    st_raddr, st_waddr;
  logic [QS_W-1:0]   st_rdata, st_wdata;

  logic              el_we, el_re;
  logic [AW-1:0]     el_addr;
  logic [ELEM_W-1:0] el_wdata, el_rdata;

  // capacity registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= {NUM_CAP{CAP_W'(CAP_RESET)}};
    end else if (cfg_i.valid) begin
      cap_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // sequencer
  mqf_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_i),
    .rsp        (rsp_o),
    .cap_i      (cap_q),
    .st_re_o    (st_re),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .el_we_o    (el_we),
    .el_re_o    (el_re),
    .el_addr_o  (el_addr),
    .el_wdata_o (el_wdata),
    .el_rdata_i (el_rdata)
  );

  // queue state words
  mqf_state_ram #(
    .DEPTH(NUM_QUEUES),
    .WIDTH(QS_W)
  ) u_state_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata)
  );

  // element store
  mqf_elem_ram #(
    .DEPTH(EL_D),
    .WIDTH(ELEM_W)
  ) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (el_we),
    .re_i   (el_re),
    .addr_i (el_addr),
    .wdata_i(el_wdata),
    .rdata_o(el_rdata)
  );

endmodule

### sim/mqf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqf_checker
// Watches the request, result and capacity channels of the multi-queue ring
// fifo. Keeps its own copy of every queue, its pointers, counts, statistics
// and capacities. Each accepted request yields one predicted result. Each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mqf_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mqf_in_if    req,
  mqf_out_if   rsp,
  mqf_cfg_if   cfg,
  output int   err_count_o,
  output int   pending_o
);
  import mqf_pkg::*;

  localparam int unsigned NQ    = NUM_QUEUES_DEF;
  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  typedef struct packed {
    status_e              status;
    logic [ELEM_W-1:0]    data;
    logic [CNT_OUT_W-1:0] count;
    logic [STAT_W-1:0]    inserts;
    logic [STAT_W-1:0]    removes;
    logic [STAT_W-1:0]    empties;
    logic [STAT_W-1:0]    fulls;
  } rsp_beat_t;

  // shadow of the queues and their bookkeeping
  logic [ELEM_W-1:0]    slots   [NQ][DEPTH];
  logic [PTR_W-1:0]     wr_ptr  [NQ];
  logic [PTR_W-1:0]     rd_ptr  [NQ];
  logic [CNT_OUT_W-1:0] fill    [NQ];
  logic [STAT_W-1:0]    n_ins   [NQ];
  logic [STAT_W-1:0]    n_rem   [NQ];
  logic [STAT_W-1:0]    n_empty [NQ];
  logic [STAT_W-1:0]    n_full  [NQ];
  logic [CAP_W-1:0]     cap_reg [NUM_CAP];

  rsp_beat_t rsp_owed[$];
  int        mismatches = 0;

  assign err_count_o = mismatches;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // one operation on the shadow state, returns the result it produces
  function automatic rsp_beat_t apply_op(input logic [OP_W-1:0]   op,
                                         input logic [QID_W-1:0]  q,
                                         input logic [ELEM_W-1:0] din);
    rsp_beat_t        r;
    logic [CAP_W-1:0] lim;
    r        = '0;
    r.status = ST_OK;
    // capacities above the physical depth saturate
    lim = (cap_reg[q] > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_reg[q];
    case (op)
      OP_INSERT: begin
        if (fill[q] >= lim) begin
          n_full[q] = n_full[q] + 1'b1;
          r.status  = ST_FULL;
        end else begin
          slots[q][wr_ptr[q]] = din;
          wr_ptr[q] = step_ptr(wr_ptr[q]);
          fill[q]   = fill[q] + 1'b1;
          n_ins[q]  = n_ins[q] + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (fill[q] == '0) begin
          n_empty[q] = n_empty[q] + 1'b1;
          r.status   = ST_EMPTY;
        end else begin
          r.data    = slots[q][rd_ptr[q]];
          rd_ptr[q] = step_ptr(rd_ptr[q]);
          fill[q]   = fill[q] - 1'b1;
          n_rem[q]  = n_rem[q] + 1'b1;
        end
      end
      OP_PEEK: begin
        if (fill[q] == '0) r.status = ST_EMPTY;
        else r.data = slots[q][rd_ptr[q]];
      end
      OP_FLUSH: begin
        fill[q]   = '0;
        wr_ptr[q] = '0;
        rd_ptr[q] = '0;
      end
      OP_CLEAR: begin
        n_ins[q]   = '0;
        n_rem[q]   = '0;
        n_empty[q] = '0;
        n_full[q]  = '0;
      end
      // status query and the spare codes leave the state alone
      default: ;
    endcase
    r.count   = fill[q];
    r.inserts = n_ins[q];
    r.removes = n_rem[q];
    r.empties = n_empty[q];
    r.fulls   = n_full[q];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
                             input logic [ELEM_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // sample all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_beat_t want;
    int        qi;
    if (!rst_ni) begin
      for (qi = 0; qi < NQ; qi++) begin
        wr_ptr[qi]  = '0;
        rd_ptr[qi]  = '0;
        fill[qi]    = '0;
        n_ins[qi]   = '0;
        n_rem[qi]   = '0;
        n_empty[qi] = '0;
        n_full[qi]  = '0;
      end
      for (qi = 0; qi < NUM_CAP; qi++) cap_reg[qi] = CAP_W'(CAP_RESET);
      rsp_owed.delete();
      pending_o <= 0;
    end else begin
      if (cfg.valid && cfg.ready) cap_reg[cfg.index] = cfg.data;
      if (req.valid && req.ready)
        rsp_owed.push_back(apply_op(req.op, req.queue_id, req.data_in));
      if (rsp.valid && rsp.ready) begin
        if (rsp_owed.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result beat: expected none, actual status %0h data %0h",
                   $time, rsp.status, rsp.data_out);
        end else begin
          want = rsp_owed.pop_front();
          check_field("status",       ELEM_W'(want.status),  ELEM_W'(rsp.status));
          check_field("data_out",     want.data,             rsp.data_out);
          check_field("elem_count",   ELEM_W'(want.count),   ELEM_W'(rsp.elem_count));
          check_field("insert_total", ELEM_W'(want.inserts), ELEM_W'(rsp.insert_total));
          check_field("remove_total", ELEM_W'(want.removes), ELEM_W'(rsp.remove_total));
          check_field("empty_hits",   ELEM_W'(want.empties), ELEM_W'(rsp.empty_hits));
          check_field("full_hits",    ELEM_W'(want.fulls),   ELEM_W'(rsp.full_hits));
        end
      end
      pending_o <= rsp_owed.size();
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the multi-queue ring fifo bench. A directed opening covers both
// ends of every field, every operation, full and empty queues, zero and
// saturated capacities and the spare op codes. Random bursts under several
// capacity settings follow, with random idling on both channels and one
// stretch without any. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mqf_pkg::*;

  // spare op codes, answered like a status query
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned IDLE_PCT     = 20;

  logic clk_i;
  logic rst_ni;
  int   err_count;
  int   pending;
  int   cycles = 0;
  bit   calm   = 1'b0;

  mqf_in_if  req ();
  mqf_out_if rsp ();
  mqf_cfg_if cfg ();

  multi_queue_ring_fifo uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  mqf_checker mqf_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stalls at random except in the calm stretch
  always @(posedge clk_i) begin
    rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_queue_ring_fifo verification failed");
      $finish;
    end
  end

  // one request beat, with random idle cycles in front of it
  task automatic send_op(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
                         input logic [ELEM_W-1:0] din);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.op       <= op;
    req.queue_id <= qid;
    req.data_in  <= din;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // capacity writes, only while the block is idle
  task automatic write_caps(input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                            input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3);
    cap_arr_t caps;
    int       i;
    caps[0] = c0;
    caps[1] = c1;
    caps[2] = c2;
    caps[3] = c3;
    for (i = 0; i < NUM_CAP; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= CFG_IDX_W'(i);
      cfg.data  <= caps[i];
      do @(posedge clk_i); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
  endtask

  // random traffic, leaning on one queue so it fills and wraps
  task automatic run_burst(input int unsigned n, input int unsigned ins_pct,
                           input logic [QID_W-1:0] focus);
    logic [OP_W-1:0]   op;
    logic [QID_W-1:0]  qid;
    logic [ELEM_W-1:0] din;
    int unsigned       pick;
    int unsigned       i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < ins_pct) begin
        op = OP_INSERT;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 11) op = OP_REMOVE;
        else if (pick < 14) op = OP_PEEK;
        else if (pick == 14) op = OP_FLUSH;
        else if (pick == 15) op = OP_CLEAR;
        else if (pick < 18) op = OP_STATUS;
        else if (pick == 18) op = OP_SPARE_LO;
        else op = OP_SPARE_HI;
      end
      qid  = ($urandom_range(0, 9) < 6) ? focus : QID_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 9);
      din  = (pick == 0) ? '0 : (pick == 1) ? '1 : ELEM_W'($urandom);
      send_op(op, qid, din);
      // now and then hold off until the block has caught up
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    req.valid    <= 1'b0;
    req.op       <= OP_STATUS;
    req.queue_id <= '0;
    req.data_in  <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= '0;
    cfg.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every op, empty queue cases
    send_op(OP_INSERT,   2'd0, '1);
    send_op(OP_INSERT,   2'd0, '0);
    send_op(OP_PEEK,     2'd0, '0);
    send_op(OP_REMOVE,   2'd0, '0);
    send_op(OP_REMOVE,   2'd0, '0);
    send_op(OP_REMOVE,   2'd0, '1);
    send_op(OP_PEEK,     2'd0, '0);
    send_op(OP_INSERT,   2'd1, 32'hA5A5_5A5A);
    send_op(OP_STATUS,   2'd1, '0);
    send_op(OP_SPARE_LO, 2'd1, '1);
    send_op(OP_SPARE_HI, 2'd2, '0);
    send_op(OP_FLUSH,    2'd1, '0);
    send_op(OP_REMOVE,   2'd1, '0);
    send_op(OP_CLEAR,    2'd0, '0);
    send_op(OP_STATUS,   2'd3, '1);
    drain();

    // directed: saturated, single-slot and zero capacities
    write_caps(5'd31, 5'd17, 5'd1, 5'd0);
    send_op(OP_INSERT, 2'd2, 32'h0123_4567);
    send_op(OP_INSERT, 2'd2, 32'h89AB_CDEF);
    send_op(OP_REMOVE, 2'd2, '0);
    send_op(OP_INSERT, 2'd3, '1);
    send_op(OP_CLEAR,  2'd3, '0);
    drain();

    // random bursts under changing capacities
    write_caps(5'd16, 5'd16, 5'd16, 5'd16);
    run_burst(120, 55, 2'd0);
    drain();
    write_caps(5'd1, 5'd0, 5'd16, 5'd31);
    run_burst(110, 45, 2'd2);
    drain();
    write_caps(CAP_W'($urandom_range(0, 31)), CAP_W'($urandom_range(0, 31)),
               CAP_W'($urandom_range(0, 31)), CAP_W'($urandom_range(0, 31)));
    calm = 1'b1;
    run_burst(110, 50, QID_W'($urandom_range(0, 3)));
    drain();
    calm = 1'b0;
    write_caps(CAP_W'($urandom_range(1, 16)), CAP_W'($urandom_range(1, 16)),
               CAP_W'($urandom_range(1, 16)), CAP_W'($urandom_range(1, 16)));
    run_burst(110, 35, 2'd1);
    drain();
    write_caps(5'd16, 5'd17, 5'd2, 5'd8);
    run_burst(100, 60, 2'd3);

    // wait out the pipeline, then report
    drain();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("multi_queue_ring_fifo verification clean");
    end else begin
      $display("multi_queue_ring_fifo verification failed");
    end
    $finish;
  end

endmodule
